/* design/signed_decimal_printer_macros.svh */
// ----------------------------------------------------------------------------
// Signed decimal printer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_PRINTER_MACROS_SVH
`define SIGNED_DECIMAL_PRINTER_MACROS_SVH

`ifndef SYNTHESIS
`define SDP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdp assertion failed");
`define SDP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sdp forbidden condition");
`else
`define SDP_ASSERT(lbl, clk, rst_n, prop)
`define SDP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* design/sdp_pkg.sv */
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared constants, types and conversion functions of the decimal printer.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int InWidth    = 64;
  localparam int ValueWidth = 64;   // printed width, 8..64
  localparam int CharW      = 8;

  // Magnitude padded to whole nibbles; four bits enter the converter a cycle
  localparam int MagBits    = ((ValueWidth + 3) / 4) * 4;
  localparam int Steps      = MagBits / 4;
  localparam int StepCntW   = $clog2(Steps);

  localparam int NumDigits  = 20;
  localparam int DigitIdxW  = $clog2(NumDigits);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    logic               neg;
    logic [MagBits-1:0] mag;
  } item_t;

  // Shift four bits into a BCD accumulator, MSB first (add-3 correction).
  function automatic bcd_t dabble4(bcd_t bcd_in, logic [3:0] bits);
    bcd_t b;
    b = bcd_in;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d] >= 4'd5) begin
          b[d] = b[d] + 4'd3;
        end
      end
      b = bcd_t'({b, bits[s]});
    end
    return b;
  endfunction

  // Position of the most significant nonzero digit; zero maps to digit 0.
  function automatic logic [DigitIdxW-1:0] msd_index(bcd_t b);
    logic [DigitIdxW-1:0] idx;
    idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (b[d] != 4'd0) begin
        idx = DigitIdxW'(d);
      end
    end
    return idx;
  endfunction

endpackage

/* design/sdp_front.sv */
// ----------------------------------------------------------------------------
// sdp_front
// Accepts requests, splits each value into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sdp_front (
  input  logic                              in_valid_i,
  input  logic signed [sdp_pkg::InWidth-1:0] value_i,
  output logic                              in_stall_o,
  input  logic                              q_full_i,
  output logic                              push_o,
  output sdp_pkg::item_t                    item_o
);

  logic [sdp_pkg::ValueWidth-1:0] val;
  logic [sdp_pkg::ValueWidth-1:0] mag;
  logic                           neg;

  assign val = value_i[sdp_pkg::ValueWidth-1:0];
  assign neg = val[sdp_pkg::ValueWidth-1];
  // Most negative value negates to itself, which is the right unsigned magnitude
  assign mag = neg ? (~val + 1'b1) : val;

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i & ~q_full_i;
  assign item_o.neg  = neg;
  assign item_o.mag  = sdp_pkg::MagBits'(mag);

endmodule

/* design/sdp_queue.sv */
// ----------------------------------------------------------------------------
// sdp_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`include "signed_decimal_printer_macros.svh"

module sdp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdp_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sdp_pkg::item_t item_o
);

  sdp_pkg::item_t                entry_q [sdp_pkg::QueueDepth];
  logic [sdp_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sdp_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sdp_pkg::QCntW-1:0]     cnt_q, cnt_d;

  function automatic logic [sdp_pkg::QPtrW-1:0] next_ptr(logic [sdp_pkg::QPtrW-1:0] p);
    return (p == sdp_pkg::QPtrW'(sdp_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == sdp_pkg::QCntW'(sdp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  `SDP_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `SDP_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && !valid_o)
  `SDP_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > sdp_pkg::QCntW'(sdp_pkg::QueueDepth))

endmodule

/* design/sdp_back.sv */
// ----------------------------------------------------------------------------
// sdp_back
// Converts one magnitude to BCD and emits its characters: a '-' first for a negative value, then digits MSD first.
// ----------------------------------------------------------------------------
`include "signed_decimal_printer_macros.svh"

module sdp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  sdp_pkg::item_t              q_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  output logic [sdp_pkg::CharW-1:0]   character_o,
  output logic                        is_last_o,
  input  logic                        out_stall_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StLen  = 4'b0100,
    StEmit = 4'b1000
  } back_state_e;

  back_state_e                     state_q, state_d;
  logic [sdp_pkg::StepCntW-1:0]    cnt_q, cnt_d;
  logic [sdp_pkg::DigitIdxW-1:0]   idx_q, idx_d;
  logic                            sign_pend_q, sign_pend_d;
  logic                            out_valid_q, out_valid_d;
  logic                            neg_q, neg_d;
  logic [sdp_pkg::MagBits-1:0]     mag_q, mag_d;
  sdp_pkg::bcd_t                   bcd_q, bcd_d;
  logic [sdp_pkg::CharW-1:0]       char_q, char_d;
  logic                            last_q, last_d;
  logic                            load;

  // Output register may take a new character when empty or being drained
  assign load = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q & out_stall_i;
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          neg_d   = q_item_i.neg;
          mag_d   = q_item_i.mag;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = sdp_pkg::dabble4(bcd_q, mag_q[sdp_pkg::MagBits-1 -: 4]);
        mag_d = mag_q << 4;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sdp_pkg::StepCntW'(sdp_pkg::Steps - 1)) begin
          state_d = StLen;
        end
      end
      StLen: begin
        idx_d       = sdp_pkg::msd_index(bcd_q);
        sign_pend_d = neg_q;
        state_d     = StEmit;
      end
      StEmit: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            char_d      = sdp_pkg::AsciiMinus;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            char_d = sdp_pkg::AsciiZero | {4'b0000, bcd_q[idx_q]};
            last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;

  `SDP_ASSERT(a_pop_idle, clk_i, rst_ni, pop_o |-> state_q == StIdle)
  `SDP_ASSERT(a_minus_not_last, clk_i, rst_ni, (out_valid_q && char_q == sdp_pkg::AsciiMinus) |-> !last_q)
  `SDP_ASSERT(a_last_to_idle, clk_i, rst_ni, (state_q == StEmit && load && !sign_pend_q && idx_q == '0) |=> state_q == StIdle)
  `SDP_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, idx_q > sdp_pkg::DigitIdxW'(sdp_pkg::NumDigits - 1))

endmodule

/* design/signed_decimal_printer.sv */
// ----------------------------------------------------------------------------
// signed_decimal_printer
// Prints a signed integer as decimal ASCII text, one character per transfer
// on the output channel, most significant digit first, with a leading '-'
// for negative values and is_last_o on the final character. Only the low
// ValueWidth bits of value_i are used. The back end converts the magnitude
// four bits per cycle, then finds the leading digit and emits the characters;
// it takes the next number only after the last character. A two-entry queue
// behind the front end accepts further numbers while one is being converted
// or printed.
// ----------------------------------------------------------------------------
module signed_decimal_printer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [sdp_pkg::InWidth-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sdp_pkg::CharW-1:0]          character_o,
  output logic                               is_last_o
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  sdp_pkg::item_t push_item;
  sdp_pkg::item_t pop_item;

  sdp_front u_front (
    .in_valid_i (in_valid_i),
    .value_i    (value_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  sdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  sdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .is_last_o   (is_last_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* sim/tb_signed_decimal_printer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_printer
// Sends signed integers into the printer and checks every ASCII character
// that leaves it, in order, against characters worked out locally by repeated
// division by ten. Covers the range extremes, zero, powers of ten and random
// values of every length. Both sides idle and stall at random, and one long
// output hold fills the block up.
// ----------------------------------------------------------------------------
module tb_signed_decimal_printer;

  localparam int Radix        = 10;
  localparam int IdlePct      = 17;
  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = 80;
  localparam int CycleLimit   = 400000;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic [sdp_pkg::CharW-1:0] ch;
    logic                      last;
  } text_char_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_stall_o;
  logic signed [sdp_pkg::InWidth-1:0] value_i     = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [sdp_pkg::CharW-1:0]          character_o;
  logic                               is_last_o;

  text_char_t expected_chars[$];
  int         mismatches    = 0;
  int         cycle_count   = 0;
  logic       steady        = 1'b0;   // no idling on either side
  int         hold_req_cnt  = 0;      // bumped by a test to request a long hold
  int         hold_seen     = 0;
  int         hold_left     = 0;

  signed_decimal_printer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .is_last_o  (is_last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Decimal text of the low ValueWidth bits, sign first, last digit flagged.
  function automatic void predict_text(input logic [sdp_pkg::InWidth-1:0] v);
    logic [63:0] top;
    logic [63:0] mask;
    logic [63:0] w;
    logic [63:0] mag;
    logic [3:0]  digits [sdp_pkg::NumDigits];
    int          nd;
    int          k;
    logic        neg;
    top  = 64'd1 << (sdp_pkg::ValueWidth - 1);
    mask = top | (top - 64'd1);
    w    = 64'(v) & mask;
    neg  = (w & top) != 64'd0;
    mag  = neg ? ((64'd0 - w) & mask) : w;
    nd   = 0;
    do begin
      digits[nd] = 4'(mag % Radix);
      mag        = mag / Radix;
      nd++;
    end while (mag != 64'd0 && nd < sdp_pkg::NumDigits);
    if (neg) begin
      expected_chars.insert(expected_chars.size(),
                            text_char_t'{ch: sdp_pkg::AsciiMinus, last: 1'b0});
    end
    for (k = nd - 1; k >= 0; k--) begin
      expected_chars.insert(expected_chars.size(),
                            text_char_t'{ch: sdp_pkg::AsciiZero |
                                             sdp_pkg::CharW'(digits[k]),
                                         last: (k == 0)});
    end
  endfunction

  // Offer one value, idling first at random; valid stays high on return.
  task automatic send_value(input logic [sdp_pkg::InWidth-1:0] v);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      value_i    <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_text(v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Mix of lengths: full-width noise, short magnitudes of random sign, tiny values.
  function automatic logic [sdp_pkg::InWidth-1:0] pick_value();
    logic [63:0] v;
    int          nbits;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1, 2: begin
        nbits = $urandom_range(1, 63);
        v     = {$urandom, $urandom} & ((64'd1 << nbits) - 64'd1);
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
      default: begin
        v = 64'($urandom_range(0, 999));
        if ($urandom_range(0, 1)) v = 64'd0 - v;
      end
    endcase
    return v;
  endfunction

  // Check each accepted character, then choose the stall for the next cycle.
  always @(posedge clk_i) begin : char_sink
    text_char_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("unexpected character: got '%c' (%0d) last=%0b",
                   character_o, character_o, is_last_o);
        end
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.ch || is_last_o !== want.last) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("character mismatch: expected %0d last=%0b, got %0d last=%0b",
                     want.ch, want.last, character_o, is_last_o);
          end
        end
      end
    end
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_signed_decimal_printer NOT OK");
    $finish;
  end

  task automatic test_extremes();
    logic [63:0] top;
    logic [63:0] tens;
    top = 64'd1 << (sdp_pkg::ValueWidth - 1);
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd0 - 64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd0 - 64'd10);
    send_value(top);                 // most negative
    send_value(top - 64'd1);         // most positive
    send_value(top + 64'd1);
    send_value(top - 64'd2);
    tens = 64'd1;
    repeat (sdp_pkg::ValueWidth * 3 / 10) tens = tens * Radix;
    send_value(tens);
    send_value(tens - 64'd1);
    send_value(64'd0 - tens);
    send_value(64'd0 - (tens - 64'd1));
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    // bits above the printed width are dropped
    send_value(~((top << 1) - 64'd1) | 64'd7);
    send_value(64'd100);
    send_value(64'd0 - 64'd999);
    wait_drained();
  endtask

  task automatic test_random_values(input int count);
    repeat (count) send_value(pick_value());
  endtask

  task automatic test_steady_stream(input int count);
    steady <= 1'b1;
    repeat (count) send_value(pick_value());
    steady <= 1'b0;
  endtask

  // Hold the output off while requests keep coming, so the block backs up.
  task automatic test_output_hold(input int count);
    wait_drained();
    hold_req_cnt <= hold_req_cnt + 1;
    @(posedge clk_i);
    steady <= 1'b1;
    repeat (count) send_value(pick_value());
    steady <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random_values(150);
    test_output_hold(20);
    test_steady_stream(60);
    test_random_values(180);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_signed_decimal_printer OK");
    end else begin
      $display("tb_signed_decimal_printer NOT OK");
    end
    $finish;
  end

endmodule
